/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the heading controller modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check prop on every clock edge outside reset
`define HPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
// check prop on every clock edge, reset included
`define HPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define HPS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/hps_pkg.sv */
// ----------------------------------------------------------------------------
// hps_pkg
// Widths, constants, register map and shared types of the heading controller.
// ----------------------------------------------------------------------------
package hps_pkg;

    localparam int ANGLE_FRAC_BITS = 4;
    localparam int GAIN_FRAC       = 8;
    localparam int OUT_SHIFT       = ANGLE_FRAC_BITS + GAIN_FRAC;

    localparam int ANG_W   = 14;  // input angle width
    localparam int ERR_W   = 16;  // wrapped error
    localparam int INT_W   = 15;  // integrator
    localparam int SUM_W   = 17;  // integrator plus error
    localparam int GAIN_W  = 16;
    localparam int BAND_W  = 12;
    localparam int LIM_W   = 14;
    localparam int PROD_W  = 32;
    localparam int TOT_W   = 33;
    localparam int SPEED_W = 10;
    localparam int MAG_W   = TOT_W - OUT_SHIFT;

    localparam logic signed [ERR_W-1:0] HALF_TURN = ERR_W'(180 << ANGLE_FRAC_BITS);
    localparam logic signed [ERR_W-1:0] FULL_TURN = ERR_W'(360 << ANGLE_FRAC_BITS);
    localparam logic [MAG_W-1:0]        OUT_LIMIT = MAG_W'(500);

    // register map, index = byte address / 4
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_KP_NEAR        = 3'd0,
        REG_KI_NEAR        = 3'd1,
        REG_KP_FAR         = 3'd2,
        REG_KI_FAR         = 3'd3,
        REG_NEAR_BAND      = 3'd4,
        REG_SETTLE_BAND    = 3'd5,
        REG_INT_LIMIT_NEAR = 3'd6,
        REG_INT_LIMIT_FAR  = 3'd7
    } t_reg_idx;

    localparam logic [GAIN_W-1:0] RST_KP_NEAR        = 16'd2330;
    localparam logic [GAIN_W-1:0] RST_KI_NEAR        = 16'd15;
    localparam logic [GAIN_W-1:0] RST_KP_FAR         = 16'd6400;
    localparam logic [GAIN_W-1:0] RST_KI_FAR         = 16'd256;
    localparam logic [BAND_W-1:0] RST_NEAR_BAND      = 12'd80;
    localparam logic [BAND_W-1:0] RST_SETTLE_BAND    = 12'd6;
    localparam logic [LIM_W-1:0]  RST_INT_LIMIT_NEAR = 14'd16000;
    localparam logic [LIM_W-1:0]  RST_INT_LIMIT_FAR  = 14'd1600;

    localparam logic [1:0] SETTLE_DONE = 2'd3;

    typedef struct packed {
        logic [GAIN_W-1:0] kp_near;
        logic [GAIN_W-1:0] ki_near;
        logic [GAIN_W-1:0] kp_far;
        logic [GAIN_W-1:0] ki_far;
        logic [BAND_W-1:0] near_band;
        logic [BAND_W-1:0] settle_band;
        logic [LIM_W-1:0]  int_limit_near;
        logic [LIM_W-1:0]  int_limit_far;
    } t_cfg;

    // item after the integrator stage
    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [INT_W-1:0] integ;
        logic [GAIN_W-1:0]       kp;
        logic [GAIN_W-1:0]       ki;
        logic                    settle;
        logic                    done;
    } t_s1;

endpackage

/* rtl/heading_pi_with_settle.sv */
// ----------------------------------------------------------------------------
// heading_pi_with_settle
// PI heading controller with near/far gain scheduling and settle detection.
// ----------------------------------------------------------------------------
// Channel   Dir  Content
// s_axis    in   tdata[13:0] target_heading, tdata[27:14] measured_yaw
// m_axis    out  tdata[9:0] rotate_speed, tuser[0] done_res
// apb       in   eight 32-bit registers at byte addresses 0x00..0x1C
//
// One item per cycle unless the output stalls; each item passes through the
// input register, integrator stage, multiply stage and result register.
// The integrator and settle count update as an item leaves the input
// register, so items follow back to back.
// Reset restores default register values and clears integrator and count.
// A stalled output holds its item; upstream stages keep filling until full.
// ----------------------------------------------------------------------------
module heading_pi_with_settle (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [31:0]                 i_s_axis_tdata,   // target_heading, measured_yaw
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [15:0]                 o_m_axis_tdata,   // rotate_speed
    output logic [0:0]                  o_m_axis_tuser,   // done_res
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hps_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    hps_pkg::t_cfg               w_cfg;
    hps_pkg::t_s1                w_s1;
    logic                        w_s1_valid;
    logic                        w_s1_ready;
    logic [hps_pkg::SPEED_W-1:0] w_speed;
    logic                        w_done;

    hps_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    hps_integ u_integ (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_valid          (i_s_axis_tvalid),
        .o_ready          (o_s_axis_tready),
        .i_target_heading (i_s_axis_tdata[hps_pkg::ANG_W-1:0]),
        .i_measured_yaw   (i_s_axis_tdata[2*hps_pkg::ANG_W-1:hps_pkg::ANG_W]),
        .o_s1_valid       (w_s1_valid),
        .i_s1_ready       (w_s1_ready),
        .o_s1             (w_s1)
    );

    hps_output u_output (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s1_valid     (w_s1_valid),
        .o_s1_ready     (w_s1_ready),
        .i_s1           (w_s1),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_rotate_speed (w_speed),
        .o_done_res     (w_done)
    );

    assign o_m_axis_tdata = {{(16-hps_pkg::SPEED_W){1'b0}}, w_speed};
    assign o_m_axis_tuser = w_done;

endmodule

/* rtl/hps_regs.sv */
// ----------------------------------------------------------------------------
// hps_regs
// APB register file holding the gains, bands and integrator limits.
// ----------------------------------------------------------------------------
module hps_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [hps_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output hps_pkg::t_cfg             o_cfg
);

    hps_pkg::t_cfg    r_cfg;
    hps_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = hps_pkg::t_reg_idx'(paddr[hps_pkg::ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_near        <= hps_pkg::RST_KP_NEAR;
            r_cfg.ki_near        <= hps_pkg::RST_KI_NEAR;
            r_cfg.kp_far         <= hps_pkg::RST_KP_FAR;
            r_cfg.ki_far         <= hps_pkg::RST_KI_FAR;
            r_cfg.near_band      <= hps_pkg::RST_NEAR_BAND;
            r_cfg.settle_band    <= hps_pkg::RST_SETTLE_BAND;
            r_cfg.int_limit_near <= hps_pkg::RST_INT_LIMIT_NEAR;
            r_cfg.int_limit_far  <= hps_pkg::RST_INT_LIMIT_FAR;
        end else if (w_wr) begin
            unique case (w_idx)
                hps_pkg::REG_KP_NEAR:        r_cfg.kp_near     <= pwdata[hps_pkg::GAIN_W-1:0];
                hps_pkg::REG_KI_NEAR:        r_cfg.ki_near     <= pwdata[hps_pkg::GAIN_W-1:0];
                hps_pkg::REG_KP_FAR:         r_cfg.kp_far      <= pwdata[hps_pkg::GAIN_W-1:0];
                hps_pkg::REG_KI_FAR:         r_cfg.ki_far      <= pwdata[hps_pkg::GAIN_W-1:0];
                hps_pkg::REG_NEAR_BAND:      r_cfg.near_band   <= pwdata[hps_pkg::BAND_W-1:0];
                hps_pkg::REG_SETTLE_BAND:    r_cfg.settle_band <= pwdata[hps_pkg::BAND_W-1:0];
                hps_pkg::REG_INT_LIMIT_NEAR: r_cfg.int_limit_near <= pwdata[hps_pkg::LIM_W-1:0];
                hps_pkg::REG_INT_LIMIT_FAR:  r_cfg.int_limit_far  <= pwdata[hps_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            hps_pkg::REG_KP_NEAR:        prdata = 32'(r_cfg.kp_near);
            hps_pkg::REG_KI_NEAR:        prdata = 32'(r_cfg.ki_near);
            hps_pkg::REG_KP_FAR:         prdata = 32'(r_cfg.kp_far);
            hps_pkg::REG_KI_FAR:         prdata = 32'(r_cfg.ki_far);
            hps_pkg::REG_NEAR_BAND:      prdata = 32'(r_cfg.near_band);
            hps_pkg::REG_SETTLE_BAND:    prdata = 32'(r_cfg.settle_band);
            hps_pkg::REG_INT_LIMIT_NEAR: prdata = 32'(r_cfg.int_limit_near);
            hps_pkg::REG_INT_LIMIT_FAR:  prdata = 32'(r_cfg.int_limit_far);
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

/* rtl/hps_integ.sv */
// ----------------------------------------------------------------------------
// hps_integ
// Input register, error wrap, integrator clamp, gain select and settle count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hps_integ (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  hps_pkg::t_cfg             i_cfg,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [hps_pkg::ANG_W-1:0] i_target_heading,
    input  logic [hps_pkg::ANG_W-1:0] i_measured_yaw,
    output logic                      o_s1_valid,
    input  logic                      i_s1_ready,
    output hps_pkg::t_s1              o_s1
);

    logic                              r_v0;
    logic signed [hps_pkg::ANG_W-1:0]  r_target;
    logic signed [hps_pkg::ANG_W-1:0]  r_yaw;
    logic                              r_v1;
    hps_pkg::t_s1                      r_s1;
    hps_pkg::t_s1                      n_s1;
    logic signed [hps_pkg::INT_W-1:0]  r_integ;
    logic signed [hps_pkg::INT_W-1:0]  n_integ;
    logic [1:0]                        r_count;
    logic [1:0]                        n_count;

    logic                              w_rdy1;
    logic                              w_move;
    logic signed [hps_pkg::ERR_W-1:0]  w_err_raw;
    logic signed [hps_pkg::ERR_W-1:0]  w_err;
    logic signed [hps_pkg::SUM_W-1:0]  w_err_x;
    logic signed [hps_pkg::SUM_W-1:0]  w_sum;
    logic signed [hps_pkg::SUM_W-1:0]  w_lim;
    logic signed [hps_pkg::SUM_W-1:0]  w_clamped;
    logic signed [hps_pkg::SUM_W-1:0]  w_nb;
    logic signed [hps_pkg::SUM_W-1:0]  w_sb;
    logic                              w_near;
    logic                              w_settle;
    logic [1:0]                        w_cnt_inc;

    assign w_rdy1     = !r_v1 || i_s1_ready;
    assign o_ready    = !r_v0 || w_rdy1;
    assign w_move     = r_v0 && w_rdy1;
    assign o_s1_valid = r_v1;
    assign o_s1       = r_s1;

    always_comb begin
        w_err_raw = hps_pkg::ERR_W'(r_target) - hps_pkg::ERR_W'(r_yaw);
        // wrap once into a half turn either way
        if (w_err_raw < -hps_pkg::HALF_TURN) begin
            w_err = w_err_raw + hps_pkg::FULL_TURN;
        end else if (w_err_raw > hps_pkg::HALF_TURN) begin
            w_err = w_err_raw - hps_pkg::FULL_TURN;
        end else begin
            w_err = w_err_raw;
        end

        // the coarse clamp of 6000 degrees never binds at these widths
        w_err_x  = hps_pkg::SUM_W'(w_err);
        w_sum    = hps_pkg::SUM_W'(r_integ) + w_err_x;
        w_nb     = $signed({{(hps_pkg::SUM_W-hps_pkg::BAND_W){1'b0}}, i_cfg.near_band});
        w_sb     = $signed({{(hps_pkg::SUM_W-hps_pkg::BAND_W){1'b0}}, i_cfg.settle_band});
        w_near   = (w_err_x > -w_nb) && (w_err_x < w_nb);
        w_settle = (w_err_x > -w_sb) && (w_err_x < w_sb);

        if (w_near) begin
            w_lim = $signed({{(hps_pkg::SUM_W-hps_pkg::LIM_W){1'b0}}, i_cfg.int_limit_near});
        end else begin
            w_lim = $signed({{(hps_pkg::SUM_W-hps_pkg::LIM_W){1'b0}}, i_cfg.int_limit_far});
        end

        if (w_sum > w_lim) begin
            w_clamped = w_lim;
        end else if (w_sum < -w_lim) begin
            w_clamped = -w_lim;
        end else begin
            w_clamped = w_sum;
        end

        w_cnt_inc = r_count + 2'd1;

        n_s1.err    = w_err;
        n_s1.kp     = w_near ? i_cfg.kp_near : i_cfg.kp_far;
        n_s1.ki     = w_near ? i_cfg.ki_near : i_cfg.ki_far;
        n_s1.settle = w_settle;
        n_s1.done   = w_settle && (w_cnt_inc == hps_pkg::SETTLE_DONE);

        if (w_settle) begin
            n_integ = '0;
            n_count = (w_cnt_inc == hps_pkg::SETTLE_DONE) ? 2'd0 : w_cnt_inc;
        end else begin
            n_integ = w_clamped[hps_pkg::INT_W-1:0];
            n_count = r_count;
        end
        n_s1.integ = n_integ;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_integ <= '0;
            r_count <= 2'd0;
        end else begin
            if (o_ready) begin
                r_v0 <= i_valid;
            end
            if (w_rdy1) begin
                r_v1 <= r_v0;
            end
            // state advances once per item, as it leaves the input register
            if (w_move) begin
                r_integ <= n_integ;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_target <= i_target_heading;
            r_yaw    <= i_measured_yaw;
        end
        if (w_move) begin
            r_s1 <= n_s1;
        end
    end

    `HPS_ASSERT(a_count_never_three, i_clk, i_rst_n, r_count != hps_pkg::SETTLE_DONE, "settle count reached three")
    `HPS_ASSERT(a_settle_clears_integ, i_clk, i_rst_n, (w_move && w_settle) |=> (r_integ == '0), "integrator not cleared in settle band")
    `HPS_ASSERT(a_done_in_band, i_clk, i_rst_n, (r_v1 && r_s1.done) |-> r_s1.settle, "done outside settle band")

endmodule

/* rtl/hps_output.sv */
// ----------------------------------------------------------------------------
// hps_output
// Gain multiplies, sum, truncation toward zero, saturation, settle zeroing and result register.
// ----------------------------------------------------------------------------
module hps_output (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s1_valid,
    output logic                        o_s1_ready,
    input  hps_pkg::t_s1                i_s1,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hps_pkg::SPEED_W-1:0] o_rotate_speed,
    output logic                        o_done_res
);

    logic                               r_v2;
    logic signed [hps_pkg::PROD_W-1:0]  r_p;
    logic signed [hps_pkg::PROD_W-1:0]  r_i;
    logic                               r_settle2;
    logic                               r_done2;
    logic                               r_v3;
    logic [hps_pkg::SPEED_W-1:0]        r_speed;
    logic                               r_done3;

    logic                               w_rdy3;
    logic                               w_rdy2;
    logic signed [hps_pkg::TOT_W-1:0]   w_p_full;
    logic signed [hps_pkg::TOT_W-1:0]   w_i_full;
    logic signed [hps_pkg::TOT_W-1:0]   w_total;
    logic [hps_pkg::TOT_W-1:0]          w_abs;
    logic [hps_pkg::MAG_W-1:0]          w_mag;
    logic [hps_pkg::SPEED_W-1:0]        w_mag_sat;
    logic [hps_pkg::SPEED_W-1:0]        n_speed;

    assign w_rdy3     = !r_v3 || i_ready;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign o_s1_ready = w_rdy2;
    assign o_valid    = r_v3;
    assign o_rotate_speed = r_speed;
    assign o_done_res     = r_done3;

    always_comb begin
        // gains are unsigned: give them a zero sign bit
        w_p_full = hps_pkg::TOT_W'(i_s1.err)   * $signed({1'b0, i_s1.kp});
        w_i_full = hps_pkg::TOT_W'(i_s1.integ) * $signed({1'b0, i_s1.ki});

        w_total = hps_pkg::TOT_W'(r_p) + hps_pkg::TOT_W'(r_i);
        w_abs   = w_total[hps_pkg::TOT_W-1] ? hps_pkg::TOT_W'(-w_total)
                                            : hps_pkg::TOT_W'(w_total);
        w_mag   = w_abs[hps_pkg::TOT_W-1:hps_pkg::OUT_SHIFT];
        w_mag_sat = (w_mag > hps_pkg::OUT_LIMIT) ? hps_pkg::OUT_LIMIT[hps_pkg::SPEED_W-1:0]
                                                 : w_mag[hps_pkg::SPEED_W-1:0];
        // output is the negated, saturated sum
        if (r_settle2) begin
            n_speed = '0;
        end else if (w_total[hps_pkg::TOT_W-1]) begin
            n_speed = w_mag_sat;
        end else begin
            n_speed = -w_mag_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy2) begin
                r_v2 <= i_s1_valid;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && i_s1_valid) begin
            r_p       <= w_p_full[hps_pkg::PROD_W-1:0];
            r_i       <= w_i_full[hps_pkg::PROD_W-1:0];
            r_settle2 <= i_s1.settle;
            r_done2   <= i_s1.done;
        end
        if (w_rdy3 && r_v2) begin
            r_speed <= n_speed;
            r_done3 <= r_done2;
        end
    end

endmodule

/* sim/heading_pi_with_settle_tb.sv */
// ----------------------------------------------------------------------------
// heading_pi_with_settle_tb
// Self-checking bench for the PI heading controller. A short table of items
// covers the angle extremes, the wrap at half a turn and the settle counting.
// Random items then run under five gain settings, mostly errors that sit
// inside the settle and near bands. Results are checked against fixed table
// values or an in-bench model of the controller.
// ----------------------------------------------------------------------------
module heading_pi_with_settle_tb;

    localparam int     RESULT_LATENCY = 4;
    localparam int     PHASE_ITEMS    = 205;
    localparam int     MAX_PRINTS     = 50;
    localparam longint WRAP_HALF      = 180 << hps_pkg::ANGLE_FRAC_BITS;
    localparam longint WRAP_FULL      = 360 << hps_pkg::ANGLE_FRAC_BITS;
    localparam longint SPEED_MAX      = 500;
    localparam int     ANGLE_MAX      = 5760;

    typedef struct packed {
        logic signed [hps_pkg::SPEED_W-1:0] speed;
        logic                               done;
    } t_heading_result;

    typedef struct packed {
        int tgt;
        int yaw;
        bit has_ref;
        int speed;
        bit done_bit;
    } t_dir_row;

    localparam int DIRECTED_ROWS = 24;

    // fixed results hold only for the reset gain setting
    t_dir_row directed_rows [DIRECTED_ROWS] = '{
        '{0, 0, 1'b1, 0, 1'b0},
        '{100, 100, 1'b1, 0, 1'b0},
        '{-5760, -5760, 1'b1, 0, 1'b1},
        '{5760, -5760, 1'b1, -500, 1'b0},
        '{-5760, 5760, 1'b1, 500, 1'b0},
        '{0, 0, 1'b1, 0, 1'b0},
        '{480, 0, 1'b0, 0, 1'b0},
        '{3, 0, 1'b1, 0, 1'b0},
        '{0, 3, 1'b1, 0, 1'b1},
        '{6, 0, 1'b0, 0, 1'b0},
        '{0, 6, 1'b0, 0, 1'b0},
        '{5, 0, 1'b1, 0, 1'b0},
        '{-5, 0, 1'b1, 0, 1'b0},
        '{79, 0, 1'b0, 0, 1'b0},
        '{-80, 0, 1'b0, 0, 1'b0},
        '{80, 0, 1'b0, 0, 1'b0},
        '{2880, 0, 1'b0, 0, 1'b0},
        '{-2880, 0, 1'b0, 0, 1'b0},
        '{2880, -1, 1'b0, 0, 1'b0},
        '{-2880, 1, 1'b0, 0, 1'b0},
        '{8191, -8192, 1'b0, 0, 1'b0},
        '{-8192, 8191, 1'b0, 0, 1'b0},
        '{-1, -1, 1'b1, 0, 1'b1},
        '{5760, 5760, 1'b1, 0, 1'b0}
    };

    logic                       i_clk   = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_valid = 1'b0;
    logic [31:0]                s_data  = '0;
    logic                       m_ready = 1'b0;
    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [hps_pkg::ADDR_W-1:0] paddr   = '0;
    logic [31:0]                pwdata  = '0;
    logic                       s_ready;
    logic                       m_valid;
    logic [15:0]                m_data;
    logic [0:0]                 m_user;
    logic [31:0]                prdata;
    logic                       pready;

    t_heading_result expected_results[$];
    hps_pkg::t_cfg   gain_cfg;
    longint          integ_state;
    int              settle_state;
    int              error_count  = 0;
    int              items_sent   = 0;
    int              results_seen = 0;
    int              done_seen    = 0;
    int              stall_left   = 0;
    bit              quiet        = 1'b0;

    heading_pi_with_settle u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("heading_pi_with_settle_tb: FAIL");
        $finish;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (error_count < MAX_PRINTS)
            $display("%0t: result %0d %s: got 0x%0h, want 0x%0h",
                     $realtime, results_seen, what, got, want);
        error_count++;
    endtask

    function automatic longint clamp_mag(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // advance integrator and settle count by one item
    function automatic t_heading_result predict_heading_step(
        logic [hps_pkg::ANG_W-1:0] tgt, logic [hps_pkg::ANG_W-1:0] yaw);
        longint err, sum, kp, ki, total, mag, nb, sb;
        t_heading_result r;
        err = longint'($signed(tgt)) - longint'($signed(yaw));
        if (err < -WRAP_HALF) err += WRAP_FULL;
        else if (err > WRAP_HALF) err -= WRAP_FULL;
        nb = longint'(gain_cfg.near_band);
        sb = longint'(gain_cfg.settle_band);
        // the coarse clamp can never bind at these widths
        sum = integ_state + err;
        if (err > -nb && err < nb) begin
            sum = clamp_mag(sum, longint'(gain_cfg.int_limit_near));
            kp  = longint'(gain_cfg.kp_near);
            ki  = longint'(gain_cfg.ki_near);
        end else begin
            sum = clamp_mag(sum, longint'(gain_cfg.int_limit_far));
            kp  = longint'(gain_cfg.kp_far);
            ki  = longint'(gain_cfg.ki_far);
        end
        r.speed = '0;
        r.done  = 1'b0;
        if (err > -sb && err < sb) begin
            sum = 0;
            settle_state = (settle_state + 1) % 4;
            if (settle_state == int'(hps_pkg::SETTLE_DONE)) begin
                settle_state = 0;
                r.done = 1'b1;
            end
        end else begin
            total = err * kp + sum * ki;
            mag = (total < 0) ? -total : total;
            mag = mag >> hps_pkg::OUT_SHIFT;
            if (mag > SPEED_MAX) mag = SPEED_MAX;
            // output is the negated, truncated sum
            r.speed = hps_pkg::SPEED_W'((total < 0) ? mag : -mag);
        end
        integ_state = sum;
        return r;
    endfunction

    task automatic write_reg(hps_pkg::t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= hps_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            hps_pkg::REG_KP_NEAR:
                gain_cfg.kp_near        = value[hps_pkg::GAIN_W-1:0];
            hps_pkg::REG_KI_NEAR:
                gain_cfg.ki_near        = value[hps_pkg::GAIN_W-1:0];
            hps_pkg::REG_KP_FAR:
                gain_cfg.kp_far         = value[hps_pkg::GAIN_W-1:0];
            hps_pkg::REG_KI_FAR:
                gain_cfg.ki_far         = value[hps_pkg::GAIN_W-1:0];
            hps_pkg::REG_NEAR_BAND:
                gain_cfg.near_band      = value[hps_pkg::BAND_W-1:0];
            hps_pkg::REG_SETTLE_BAND:
                gain_cfg.settle_band    = value[hps_pkg::BAND_W-1:0];
            hps_pkg::REG_INT_LIMIT_NEAR:
                gain_cfg.int_limit_near = value[hps_pkg::LIM_W-1:0];
            hps_pkg::REG_INT_LIMIT_FAR:
                gain_cfg.int_limit_far  = value[hps_pkg::LIM_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_gains(logic [31:0] kpn, logic [31:0] kin, logic [31:0] kpf,
                             logic [31:0] kif, logic [31:0] nb, logic [31:0] sb,
                             logic [31:0] lim_near, logic [31:0] lim_far);
        write_reg(hps_pkg::REG_KP_NEAR, kpn);
        write_reg(hps_pkg::REG_KI_NEAR, kin);
        write_reg(hps_pkg::REG_KP_FAR, kpf);
        write_reg(hps_pkg::REG_KI_FAR, kif);
        write_reg(hps_pkg::REG_NEAR_BAND, nb);
        write_reg(hps_pkg::REG_SETTLE_BAND, sb);
        write_reg(hps_pkg::REG_INT_LIMIT_NEAR, lim_near);
        write_reg(hps_pkg::REG_INT_LIMIT_FAR, lim_far);
    endtask

    // hold the input side until every pending result is out
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (RESULT_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic send_heading(logic [hps_pkg::ANG_W-1:0] tgt,
                                logic [hps_pkg::ANG_W-1:0] yaw,
                                bit has_ref, t_heading_result ref_res);
        t_heading_result pred;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {4'b0, yaw, tgt};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        pred = predict_heading_step(tgt, yaw);
        expected_results.push_back(has_ref ? ref_res : pred);
        items_sent++;
    endtask

    // mostly errors inside the settle and near bands, the rest wide or raw
    task automatic send_random_heading();
        int tgt, yaw, e, sb, nb, kind;
        sb   = int'(gain_cfg.settle_band);
        nb   = int'(gain_cfg.near_band);
        tgt  = int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
        kind = $urandom_range(0, 9);
        e    = 0;
        if (kind <= 3) begin
            if (sb > 0) e = int'($urandom_range(0, 2 * (sb - 1))) - (sb - 1);
        end else if (kind <= 5) begin
            if (nb > 0) e = int'($urandom_range(0, 2 * nb)) - nb;
            else e = int'($urandom_range(0, 200)) - 100;
        end else if (kind == 6) begin
            e = 2880 + int'($urandom_range(0, 6)) - 3;
            if ($urandom_range(0, 1) == 1) e = -e;
        end
        yaw = tgt - e;
        if (kind == 7 || kind == 8) begin
            yaw = int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
        end else if (kind == 9) begin
            tgt = int'($urandom_range(0, 16383));
            yaw = int'($urandom_range(0, 16383));
        end
        send_heading(hps_pkg::ANG_W'(tgt), hps_pkg::ANG_W'(yaw), 1'b0, '0);
    endtask

    always @(posedge i_clk) begin : result_check
        t_heading_result want;
        if (i_rst_n && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("arrived with no item pending", {16'b0, m_data}, '0);
            end else begin
                want = expected_results.pop_front();
                if (m_data !== {{(16 - hps_pkg::SPEED_W){1'b0}}, want.speed})
                    report_mismatch("rotate_speed", {16'b0, m_data},
                                    {22'b0, want.speed});
                if (m_user[0] !== want.done)
                    report_mismatch("done_res", {31'b0, m_user[0]}, {31'b0, want.done});
                if (want.done) done_seen++;
            end
            results_seen++;
        end
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        t_heading_result row_res;
        gain_cfg.kp_near        = hps_pkg::RST_KP_NEAR;
        gain_cfg.ki_near        = hps_pkg::RST_KI_NEAR;
        gain_cfg.kp_far         = hps_pkg::RST_KP_FAR;
        gain_cfg.ki_far         = hps_pkg::RST_KI_FAR;
        gain_cfg.near_band      = hps_pkg::RST_NEAR_BAND;
        gain_cfg.settle_band    = hps_pkg::RST_SETTLE_BAND;
        gain_cfg.int_limit_near = hps_pkg::RST_INT_LIMIT_NEAR;
        gain_cfg.int_limit_far  = hps_pkg::RST_INT_LIMIT_FAR;
        integ_state  = 0;
        settle_state = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            row_res.speed = hps_pkg::SPEED_W'(directed_rows[k].speed);
            row_res.done  = directed_rows[k].done_bit;
            send_heading(hps_pkg::ANG_W'(directed_rows[k].tgt),
                         hps_pkg::ANG_W'(directed_rows[k].yaw),
                         directed_rows[k].has_ref, row_res);
        end
        drain_results();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: set_gains('1, '1, '1, '1, '1, '1, '1, '1);
                2: set_gains('0, '0, '0, '0, '0, '0, '0, '0);
                3: set_gains($urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom_range(0, 2880), $urandom_range(0, 2880),
                             $urandom_range(0, 16000), $urandom_range(0, 16000));
                4: begin
                    set_gains(1200, 40, 3000, 128, 160, 12, 8000, 800);
                    quiet = 1'b1;
                end
                default: ;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random_heading();
                if (ph == 0 && n == PHASE_ITEMS / 2) drain_results();
            end
            drain_results();
        end

        $display("covered %0d items and %0d results, %0d settle completions",
                 items_sent, results_seen, done_seen);
        $display("gain settings: reset, all ones, all zeros, random, moderate");
        if (error_count == 0) begin
            $display("heading_pi_with_settle_tb: PASS");
        end else begin
            $display("heading_pi_with_settle_tb: FAIL");
        end
        $finish;
    end

endmodule
